// File: src/tlbs_pkg.sv
`default_nettype none

package tlbs_pkg;

    localparam int TEMP_W   = 8;
    localparam int THR_W    = 7;
    localparam int LEVEL_W  = 8;
    localparam int TGT_W    = 10;
    localparam int NUM_W    = 16;
    localparam int QUO_W    = 13;
    localparam int CNT_W    = 4;
    localparam int OUT_W    = 24;

    localparam logic [THR_W-1:0]   THR_RESET   = 7'd60;
    localparam logic [THR_W-1:0]   THR_MIN     = 7'd10;
    localparam logic [THR_W-1:0]   THR_MAX     = 7'd89;
    localparam logic [THR_W-1:0]   MARGIN      = 7'd10;
    localparam logic [THR_W-1:0]   DIV_BIAS    = 7'd100;
    localparam logic [CNT_W-1:0]   DIV_LAST    = 4'd15;
    localparam logic [QUO_W-1:0]   JUMP_GAP    = 13'd120;
    localparam logic [QUO_W-1:0]   GAP_BIG     = 13'd40;
    localparam logic [QUO_W-1:0]   GAP_MID     = 13'd20;
    localparam logic [QUO_W-1:0]   GAP_SMALL   = 13'd10;
    localparam logic [QUO_W-1:0]   LEVEL_MAX   = 13'd255;
    localparam logic [QUO_W-1:0]   TGT_FIELD_MAX = 13'd1023;

    typedef struct packed {
        logic load;
        logic div_step;
        logic slew;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } sts_t;

endpackage

`default_nettype wire

// File: src/tlbs_ctrl.sv
`default_nettype none

module tlbs_ctrl
    import tlbs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire logic in_failed,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      cmd,
    input  sts_t      sts
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_SLEW = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.div_step = 1'b0;
        cmd.slew     = 1'b0;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && !in_failed)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = ST_SLEW;
                end
            end
            ST_SLEW:
            begin
                cmd.slew   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: src/tlbs_dp.sv
`default_nettype none

module tlbs_dp
    import tlbs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [THR_W-1:0]   cfg_thr,
    input  wire logic [TEMP_W-1:0]  temperature,
    input  cmd_t                    cmd,
    output sts_t                    sts,
    output logic [LEVEL_W-1:0]      led_level,
    output logic [TGT_W-1:0]        target_level
);

    logic [THR_W-1:0]   thr_reg;
    logic [THR_W-1:0]   div_reg;
    logic [THR_W-1:0]   rem_reg;
    logic [THR_W-1:0]   rem_next;
    logic [NUM_W-1:0]   quo_reg;
    logic [NUM_W-1:0]   quo_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [LEVEL_W-1:0] cur_reg;
    logic [LEVEL_W-1:0] cur_next;
    logic [LEVEL_W-1:0] led_reg;
    logic [TGT_W-1:0]   tgt_reg;
    logic [TGT_W-1:0]   tgt_next;

    logic [THR_W-1:0]   thr_used;
    logic [THR_W-1:0]   base;
    logic [TEMP_W-1:0]  diff;
    logic [NUM_W-1:0]   num;
    logic [THR_W:0]     trial;
    logic               ge;
    logic [QUO_W-1:0]   tgt;
    logic [QUO_W-1:0]   cur_w;
    logic [QUO_W-1:0]   gap;
    logic [QUO_W-1:0]   step;
    logic [QUO_W-1:0]   cand;
    logic               up;

    // threshold clamp and numerator 255*(t-base), zero when t <= base
    always_comb
    begin
        if (thr_reg < THR_MIN)
        begin
            thr_used = THR_MIN;
        end
        else if (thr_reg > THR_MAX)
        begin
            thr_used = THR_MAX;
        end
        else
        begin
            thr_used = thr_reg;
        end
        base = thr_used - MARGIN;
        if (temperature > {1'b0, base})
        begin
            diff = temperature - {1'b0, base};
        end
        else
        begin
            diff = '0;
        end
        num = {diff, 8'b0} - {8'b0, diff};
    end

    // restoring divider, one quotient bit per cycle
    always_comb
    begin
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        ge       = trial >= {1'b0, div_reg};
        if (ge)
        begin
            rem_next = THR_W'(trial - {1'b0, div_reg});
        end
        else
        begin
            rem_next = trial[THR_W-1:0];
        end
        quo_next = {quo_reg[NUM_W-2:0], ge};
        sts.div_done = (cnt_reg == DIV_LAST);
    end

    // slew toward target (jump straight to it on a large gap), then clamp
    always_comb
    begin
        tgt   = quo_reg[QUO_W-1:0];
        cur_w = {{(QUO_W-LEVEL_W){1'b0}}, cur_reg};
        up    = tgt > cur_w;
        gap   = up ? (tgt - cur_w) : (cur_w - tgt);
        priority if (gap > GAP_BIG)
        begin
            step = 13'd10;
        end
        else if (gap > GAP_MID)
        begin
            step = 13'd5;
        end
        else if (gap > GAP_SMALL)
        begin
            step = 13'd2;
        end
        else
        begin
            step = 13'd1;
        end
        priority if (gap > JUMP_GAP)
        begin
            cand = tgt;
        end
        else if (gap == '0)
        begin
            cand = cur_w;
        end
        else if (up)
        begin
            cand = cur_w + step;
        end
        else
        begin
            cand = cur_w - step;
        end
        cur_next = (cand > LEVEL_MAX) ? LEVEL_W'(LEVEL_MAX) : cand[LEVEL_W-1:0];
        tgt_next = (tgt > TGT_FIELD_MAX) ? TGT_W'(TGT_FIELD_MAX) : tgt[TGT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
            cur_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_thr;
            end
            if (cmd.slew)
            begin
                cur_reg <= cur_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            div_reg <= DIV_BIAS - thr_used;
            rem_reg <= '0;
            quo_reg <= num;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.slew)
        begin
            led_reg <= cur_next;
            tgt_reg <= tgt_next;
        end
    end

    assign led_level    = led_reg;
    assign target_level = tgt_reg;

endmodule

`default_nettype wire

// File: src/thermal_led_brightness_slew.sv
`default_nettype none

// Thermal LED brightness slew.
// Input stream: one temperature sample per item, tdata = temperature,
// tuser = read-failure flag. A failed sample is taken while idle and
// gives no result. A good sample is mapped to a brightness target,
// the stored level slews toward it and one result item follows.
// Output stream: tdata = led_level (bits 7:0), target_level (bits 17:8).
// After accept, the 16-step restoring divider runs, then a slew state
// loads the output register, after which tvalid rises. One item is in
// flight at a time: s_axis_tready is high only when the block is idle,
// so the next sample is accepted only after the result has been taken.
// A stalled receiver holds the result in the output register and keeps
// s_axis_tready low until the item is taken.
// cfg channel writes low_threshold; always ready, write only when idle.
// Reset: level 0, low_threshold 60, no result pending.
module thermal_led_brightness_slew
    import tlbs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [THR_W-1:0]  cfg_data,        // low_threshold
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [TEMP_W-1:0] s_axis_tdata,    // temperature
    input  wire logic [0:0]        s_axis_tuser,    // read_failed
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [OUT_W-1:0]       m_axis_tdata     // led_level, target_level, zero pad
);

    cmd_t               cmd;
    sts_t               sts;
    logic [LEVEL_W-1:0] led_level;
    logic [TGT_W-1:0]   target_level;

    assign cfg_ready = 1'b1;

    tlbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_failed (s_axis_tuser[0]),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    tlbs_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid),
        .cfg_thr      (cfg_data),
        .temperature  (s_axis_tdata),
        .cmd          (cmd),
        .sts          (sts),
        .led_level    (led_level),
        .target_level (target_level)
    );

    assign m_axis_tdata = {{(OUT_W-LEVEL_W-TGT_W){1'b0}}, target_level, led_level};

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");

    a_failed_no_work: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser[0]) |=> s_axis_tready)
        else $error("failed sample started work");

    a_good_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !s_axis_tuser[0])
            |=> (!s_axis_tready && !m_axis_tvalid))
        else $error("good sample not processed");
`endif

endmodule

`default_nettype wire
